>>> hdl/vtfd_pkg.sv
// Shared constants, codes and result types for the transaction frame decoder.
package vtfd_pkg;

    localparam int LEN_BITS = 20;
    localparam int CFG_BITS = 32;
    localparam int IN_TDATA_BITS = ((8 + LEN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = 432;

    localparam logic [CFG_BITS-1:0] MAX_PAYLOAD_RESET = 32'd65536;

    // header layout offsets
    localparam int OFS_NONCE = 4;
    localparam int OFS_FEE = 12;
    localparam int OFS_V1_LEN = 20;
    localparam int OFS_PRIO = 20;
    localparam int OFS_LIMIT = 28;
    localparam int OFS_PRICE = 36;
    localparam int OFS_V2_LEN = 44;
    localparam int OFS_LONG_END = 48;

    localparam int PAY_OFS_V1 = 24;
    localparam int PAY_OFS_SHORT = 32;
    localparam int PAY_OFS_LONG = 48;

    localparam int DEC_V1 = 23;
    localparam int DEC_SHORT = 31;
    localparam int DEC_LONG = 47;

    localparam logic [31:0] VER_V2 = 32'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_MISMATCH  = 2'd3
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        t_status     status;
        logic [31:0] version;
        logic [63:0] nonce;
        logic [63:0] fee;
        logic [63:0] max_fee;
        logic [63:0] prio;
        logic [63:0] limit;
        logic [63:0] price;
    } t_summary;

    // results caused by one byte: an optional payload byte, an optional summary
    typedef struct packed {
        logic     pay_v;
        logic [7:0] pay_byte;
        logic     sum_v;
        t_summary summary;
    } t_bundle;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        t_summary   summary;
        logic       last;
    } t_result;

endpackage

>>> hdl/vtfd_core.sv
// Header capture, layout decision and frame checks for one byte per cycle while i_step is high.
module vtfd_core
    import vtfd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_wdata,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic [LEN_BITS-1:0] i_len,
    output t_bundle             o_bundle
);

    typedef struct packed {
        t_status status;
        logic    is_short;
    } t_check;

    logic [CFG_BITS-1:0] r_max_payload;
    logic [LEN_BITS-1:0] r_offset, n_offset;
    logic [31:0]         r_version, n_version;
    logic [63:0]         r_nonce, n_nonce;
    logic [63:0]         r_fee, n_fee;
    logic [63:0]         r_prio, n_prio;
    logic [63:0]         r_limit, n_limit;
    logic [63:0]         r_price, n_price;
    logic [31:0]         r_length, n_length;
    logic                r_short, n_short;
    logic                r_hv, n_hv;

    logic [LEN_BITS:0]   w_next_off;
    logic                w_end;
    logic                w_v2;
    logic [2:0]          w_lane8;
    logic [1:0]          w_lane4;
    t_check              w_chk;

    function automatic t_check check_frame(
        input logic [LEN_BITS-1:0] len,
        input logic [31:0]         version,
        input logic [31:0]         limit_lo,
        input logic [31:0]         length,
        input logic [CFG_BITS-1:0] max_pay
    );
        t_check      c;
        logic [31:0] plen;
        logic [5:0]  off;
        logic        fail;
        c.status   = ST_OK;
        c.is_short = 1'b0;
        plen       = length;
        off        = 6'(PAY_OFS_V1);
        fail       = 1'b0;
        if (len < LEN_BITS'(PAY_OFS_V1)) begin
            fail = 1'b1;
        end else if (version >= VER_V2) begin
            if (len < LEN_BITS'(PAY_OFS_SHORT)) begin
                fail = 1'b1;
            end else if ((33'(limit_lo) + 33'(PAY_OFS_SHORT)) == 33'(len)) begin
                c.is_short = 1'b1;
                plen       = limit_lo;
                off        = 6'(PAY_OFS_SHORT);
            end else if (len < LEN_BITS'(PAY_OFS_LONG)) begin
                fail = 1'b1;
            end else begin
                off = 6'(PAY_OFS_LONG);
            end
        end
        if (fail) begin
            c.status   = ST_SHORT;
            c.is_short = 1'b0;
        end else if (plen > max_pay) begin
            c.status = ST_TOO_LARGE;
        end else if ((33'(plen) + 33'(off)) != 33'(len)) begin
            c.status = ST_MISMATCH;
        end
        return c;
    endfunction

    assign w_next_off = {1'b0, r_offset} + 1'b1;
    assign w_end      = w_next_off >= {1'b0, i_len};
    assign w_lane8    = r_offset[2:0] - 3'd4;
    assign w_lane4    = r_offset[1:0];

    // capture header bytes into the little-endian words
    always_comb begin
        n_version = r_version;
        n_nonce   = r_nonce;
        n_fee     = r_fee;
        n_prio    = r_prio;
        n_limit   = r_limit;
        n_price   = r_price;
        n_length  = r_length;
        if (r_offset < LEN_BITS'(OFS_NONCE)) begin
            n_version[{r_offset[1:0], 3'b000} +: 8] = r_version[{r_offset[1:0], 3'b000} +: 8]
                                                    | i_byte;
        end else if (r_offset < LEN_BITS'(OFS_FEE)) begin
            n_nonce[{w_lane8, 3'b000} +: 8] = r_nonce[{w_lane8, 3'b000} +: 8] | i_byte;
        end else if (r_offset < LEN_BITS'(OFS_V1_LEN)) begin
            n_fee[{w_lane8, 3'b000} +: 8] = r_fee[{w_lane8, 3'b000} +: 8] | i_byte;
        end
        if (r_offset >= LEN_BITS'(OFS_PRIO)) begin
            if (r_version < VER_V2) begin
                if (r_offset < LEN_BITS'(PAY_OFS_V1)) begin
                    n_length[{w_lane4, 3'b000} +: 8] = r_length[{w_lane4, 3'b000} +: 8]
                                                     | i_byte;
                end
            end else begin
                if (r_offset < LEN_BITS'(OFS_LIMIT)) begin
                    n_prio[{w_lane8, 3'b000} +: 8] = r_prio[{w_lane8, 3'b000} +: 8] | i_byte;
                end else if (!r_short) begin
                    if (r_offset < LEN_BITS'(OFS_PRICE)) begin
                        n_limit[{w_lane8, 3'b000} +: 8] = r_limit[{w_lane8, 3'b000} +: 8]
                                                        | i_byte;
                    end else if (r_offset < LEN_BITS'(OFS_V2_LEN)) begin
                        n_price[{w_lane8, 3'b000} +: 8] = r_price[{w_lane8, 3'b000} +: 8]
                                                        | i_byte;
                    end else if (r_offset < LEN_BITS'(OFS_LONG_END)) begin
                        n_length[{w_lane4, 3'b000} +: 8] = r_length[{w_lane4, 3'b000} +: 8]
                                                         | i_byte;
                    end
                end
            end
        end
    end

    assign w_v2  = n_version >= VER_V2;
    assign w_chk = check_frame(i_len, n_version, n_limit[31:0], n_length, r_max_payload);

    // layout decision and next offset
    always_comb begin
        n_short  = r_short;
        n_hv     = r_hv;
        n_offset = w_next_off[LEN_BITS-1:0];
        if (!w_v2 && r_offset == LEN_BITS'(DEC_V1)) begin
            n_hv = (w_chk.status == ST_OK);
        end else if (w_v2 && r_offset == LEN_BITS'(DEC_SHORT)) begin
            n_short = (33'(n_limit[31:0]) + 33'(PAY_OFS_SHORT)) == 33'(i_len);
            if (n_short) begin
                n_hv = (w_chk.status == ST_OK);
            end
        end else if (w_v2 && r_offset == LEN_BITS'(DEC_LONG) && !r_short) begin
            n_hv = (w_chk.status == ST_OK);
        end
        if (w_end) begin
            n_offset = '0;
            n_short  = 1'b0;
            n_hv     = 1'b0;
        end
    end

    always_comb begin
        o_bundle          = '0;
        o_bundle.pay_v    = r_hv;
        o_bundle.pay_byte = i_byte;
        o_bundle.sum_v    = w_end;
        o_bundle.summary.status = w_chk.status;
        if (w_chk.status == ST_OK) begin
            o_bundle.summary.version = n_version;
            o_bundle.summary.nonce   = n_nonce;
            o_bundle.summary.fee     = n_fee;
            if (w_v2) begin
                o_bundle.summary.max_fee = n_fee;
                o_bundle.summary.prio    = n_prio;
                if (!w_chk.is_short) begin
                    o_bundle.summary.limit = n_limit;
                    o_bundle.summary.price = n_price;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_version <= '0;
            r_nonce   <= '0;
            r_fee     <= '0;
            r_prio    <= '0;
            r_limit   <= '0;
            r_price   <= '0;
            r_length  <= '0;
            r_short   <= 1'b0;
            r_hv      <= 1'b0;
        end else if (i_step) begin
            r_offset <= n_offset;
            r_short  <= n_short;
            r_hv     <= n_hv;
            if (w_end) begin
                // clear the header words for the next frame
                r_version <= '0;
                r_nonce   <= '0;
                r_fee     <= '0;
                r_prio    <= '0;
                r_limit   <= '0;
                r_price   <= '0;
                r_length  <= '0;
            end else begin
                r_version <= n_version;
                r_nonce   <= n_nonce;
                r_fee     <= n_fee;
                r_prio    <= n_prio;
                r_limit   <= n_limit;
                r_price   <= n_price;
                r_length  <= n_length;
            end
        end
    end

endmodule

>>> hdl/vtfd_out_buf.sv
// Result register: holds the results of one byte and hands them out in order.
module vtfd_out_buf
    import vtfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_bundle i_bundle,
    input  logic    i_out_ready,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_result
);

    logic       r_pay_v, n_pay_v;
    logic       r_sum_v, n_sum_v;
    logic [7:0] r_pay_byte;
    t_summary   r_summary;
    logic       w_pop;

    assign o_valid    = r_pay_v || r_sum_v;
    assign w_pop      = o_valid && i_out_ready;
    // room when empty, or when the single pending result leaves this cycle
    assign o_can_load = !o_valid || (w_pop && (r_pay_v ^ r_sum_v));

    always_comb begin
        o_result = '0;
        if (r_pay_v) begin
            o_result.kind         = KIND_PAYLOAD;
            o_result.payload_byte = r_pay_byte;
            o_result.last         = !r_sum_v;
        end else begin
            o_result.kind    = KIND_SUMMARY;
            o_result.summary = r_summary;
            o_result.last    = 1'b1;
        end
    end

    always_comb begin
        n_pay_v = r_pay_v;
        n_sum_v = r_sum_v;
        if (i_load) begin
            n_pay_v = i_bundle.pay_v;
            n_sum_v = i_bundle.sum_v;
        end else if (w_pop) begin
            // drop the payload result first, then the summary
            if (r_pay_v) begin
                n_pay_v = 1'b0;
            end else begin
                n_sum_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pay_v <= 1'b0;
            r_sum_v <= 1'b0;
        end else begin
            r_pay_v <= n_pay_v;
            r_sum_v <= n_sum_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pay_byte <= i_bundle.pay_byte;
            r_summary  <= i_bundle.summary;
        end
    end

endmodule

>>> hdl/versioned_tx_frame_decoder.sv
// Versioned transaction frame decoder: input register, decode core, result register.
// Throughput: one byte per cycle when the output is ready, set by the single decode pass;
// a byte that ends a frame while emitting payload yields two results and can stall the input.
// Reset (i_rst_n low, synchronous) empties both registers, clears the frame state
// and sets the payload limit to 65536.
module versioned_tx_frame_decoder
    import vtfd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_BITS-1:0]       i_cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // data_byte [7:0], frame_length [27:8], zero [31:28]
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // payload_byte, status, version, nonce, fee, max fee, priority_fee,
    // compute limit, compute price, zero pad
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    // kind
    output logic                      m_axis_tuser,
    output logic                      m_axis_tlast
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic [LEN_BITS-1:0] r_in_len;
    t_bundle             w_bundle;
    logic                w_has_result;
    logic                w_can_load;
    logic                w_step;
    logic                w_in_accept;
    t_result             w_result;

    assign w_has_result  = w_bundle.pay_v || w_bundle.sum_v;
    assign w_step        = r_in_valid && (!w_has_result || w_can_load);
    assign s_axis_tready = !r_in_valid || w_step;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte <= s_axis_tdata[7:0];
            r_in_len  <= s_axis_tdata[8 +: LEN_BITS];
        end
    end

    vtfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_len       (r_in_len),
        .o_bundle    (w_bundle)
    );

    vtfd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_step && w_has_result),
        .i_bundle    (w_bundle),
        .i_out_ready (m_axis_tready),
        .o_can_load  (w_can_load),
        .o_valid     (m_axis_tvalid),
        .o_result    (w_result)
    );

    assign m_axis_tuser = w_result.kind;
    assign m_axis_tlast = w_result.last;
    assign m_axis_tdata = {6'b0,
                           w_result.summary.price,
                           w_result.summary.limit,
                           w_result.summary.prio,
                           w_result.summary.max_fee,
                           w_result.summary.fee,
                           w_result.summary.nonce,
                           w_result.summary.version,
                           w_result.summary.status,
                           w_result.payload_byte};

endmodule

>>> bench/tb_versioned_tx_frame_decoder.sv
// Self-checking bench for the versioned transaction frame decoder: random frames, stalls, checks.
module tb_versioned_tx_frame_decoder;
    import vtfd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 4;

    // result tdata field positions
    localparam int FLD_PAY    = 0;
    localparam int FLD_STATUS = 8;
    localparam int FLD_VER    = 10;
    localparam int FLD_NONCE  = 42;
    localparam int FLD_FEE    = 106;
    localparam int FLD_MAXFEE = 170;
    localparam int FLD_PRIO   = 234;
    localparam int FLD_LIMIT  = 298;
    localparam int FLD_PRICE  = 362;

    typedef enum int {
        FR_V1, FR_SHORT, FR_LONG, FR_TOO_SHORT, FR_TOO_LARGE, FR_MISMATCH, FR_LEN_SHIFT, FR_NOISE
    } t_frame_shape;

    typedef enum int {
        FILL_RANDOM, FILL_ZERO, FILL_ONES
    } t_fill;

    class tx_frame_scoreboard;
        t_result     expected_results[$];
        int          mismatches;
        int          payload_seen;
        int          status_seen[4];
        logic [31:0] max_payload;
        logic [19:0] offset;
        logic [31:0] ver;
        logic [63:0] nonce, fee, prio, limit, price;
        logic [31:0] plen_word;
        bit          short_flag, hdr_ok;

        function new();
            mismatches = 0;
            payload_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            max_payload = MAX_PAYLOAD_RESET;
            clear_frame();
        endfunction

        function void clear_frame();
            offset = '0;
            ver = '0;
            nonce = '0;
            fee = '0;
            prio = '0;
            limit = '0;
            price = '0;
            plen_word = '0;
            short_flag = 1'b0;
            hdr_ok = 1'b0;
        endfunction

        // merge byte b into word w when offset o falls inside [base, base+n)
        function logic [63:0] ins(logic [63:0] w, int unsigned o, int unsigned base,
                                  int unsigned n, logic [7:0] b);
            if (o >= base && o < base + n)
                return w | (64'(b) << (8 * (o - base)));
            return w;
        endfunction

        function t_status judge(logic [19:0] len, output bit is_short);
            logic [63:0] len64, lo, plen, base;
            len64 = 64'(len);
            lo = {32'b0, limit[31:0]};
            is_short = 1'b0;
            if (len64 < PAY_OFS_V1) return ST_SHORT;
            if (ver < VER_V2) begin
                plen = {32'b0, plen_word};
                base = PAY_OFS_V1;
            end else begin
                if (len64 < PAY_OFS_SHORT) return ST_SHORT;
                if (64'(PAY_OFS_SHORT) + lo == len64) begin
                    is_short = 1'b1;
                    plen = lo;
                    base = PAY_OFS_SHORT;
                end else begin
                    if (len64 < PAY_OFS_LONG) return ST_SHORT;
                    plen = {32'b0, plen_word};
                    base = PAY_OFS_LONG;
                end
            end
            if (plen > {32'b0, max_payload}) return ST_TOO_LARGE;
            if (base + plen != len64) return ST_MISMATCH;
            return ST_OK;
        endfunction

        function void decide(logic [19:0] len);
            bit s;
            hdr_ok = (judge(len, s) == ST_OK);
        endfunction

        function void note_byte(logic [7:0] b, logic [19:0] len);
            int unsigned o;
            bit          pay, v2, ends, s;
            t_result     r;
            t_status     st;
            o = offset;
            pay = hdr_ok;
            ver = 32'(ins({32'b0, ver}, o, 0, 4, b));
            nonce = ins(nonce, o, OFS_NONCE, 8, b);
            fee = ins(fee, o, OFS_FEE, 8, b);
            v2 = (ver >= VER_V2);
            if (o >= OFS_V1_LEN) begin
                if (!v2) begin
                    plen_word = 32'(ins({32'b0, plen_word}, o, OFS_V1_LEN, 4, b));
                end else begin
                    prio = ins(prio, o, OFS_PRIO, 8, b);
                    // short layout stops capturing once chosen
                    if (!short_flag) begin
                        limit = ins(limit, o, OFS_LIMIT, 8, b);
                        price = ins(price, o, OFS_PRICE, 8, b);
                        plen_word = 32'(ins({32'b0, plen_word}, o, OFS_V2_LEN, 4, b));
                    end
                end
            end

            if (!v2 && o == DEC_V1) begin
                decide(len);
            end else if (v2 && o == DEC_SHORT) begin
                short_flag = (64'(PAY_OFS_SHORT) + {32'b0, limit[31:0]} == 64'(len));
                if (short_flag) decide(len);
            end else if (v2 && o == DEC_LONG && !short_flag) begin
                decide(len);
            end

            ends = (64'(o) + 64'd1 >= 64'(len));
            if (pay) begin
                r = '0;
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                r.last = !ends;
                expected_results = {expected_results, r};
            end
            if (ends) begin
                st = judge(len, s);
                r = '0;
                r.kind = KIND_SUMMARY;
                r.summary.status = st;
                if (st == ST_OK) begin
                    r.summary.version = ver;
                    r.summary.nonce = nonce;
                    r.summary.fee = fee;
                    if (v2) begin
                        r.summary.max_fee = fee;
                        r.summary.prio = prio;
                        if (!s) begin
                            r.summary.limit = limit;
                            r.summary.price = price;
                        end
                    end
                end
                r.last = 1'b1;
                expected_results = {expected_results, r};
                clear_frame();
            end else begin
                offset = 20'(o + 1);
            end
        endfunction

        function void field_check(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t  %s: expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic kind, logic [OUT_TDATA_BITS-1:0] data, logic last);
            t_result e;
            if (expected_results.size() == 0) begin
                $display("%0t  result: expected none, actual kind %0d tdata %0h",
                         $time, kind, data);
                mismatches++;
                return;
            end
            e = expected_results.pop_front();
            if (e.kind == KIND_PAYLOAD) payload_seen++;
            else status_seen[int'(e.summary.status)]++;
            field_check("kind", 64'(e.kind), 64'(kind));
            field_check("payload_byte", 64'(e.payload_byte), 64'(data[FLD_PAY +: 8]));
            field_check("status", 64'(e.summary.status), 64'(data[FLD_STATUS +: 2]));
            field_check("version", 64'(e.summary.version), 64'(data[FLD_VER +: 32]));
            field_check("nonce", e.summary.nonce, data[FLD_NONCE +: 64]);
            field_check("fee", e.summary.fee, data[FLD_FEE +: 64]);
            field_check("max fee", e.summary.max_fee, data[FLD_MAXFEE +: 64]);
            field_check("priority fee", e.summary.prio, data[FLD_PRIO +: 64]);
            field_check("limit", e.summary.limit, data[FLD_LIMIT +: 64]);
            field_check("price", e.summary.price, data[FLD_PRICE +: 64]);
            field_check("last", 64'(e.last), 64'(last));
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_BITS-1:0]       i_cfg_wdata;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                      m_axis_tuser;
    logic                      m_axis_tlast;

    tx_frame_scoreboard sb;
    logic [31:0]        cur_max = MAX_PAYLOAD_RESET;
    logic [7:0]         hdr [48];
    logic [7:0]         frame_data[$];
    logic [19:0]        frame_len[$];
    bit                 no_idle = 1'b0;
    bit                 hold_request = 1'b0;
    int                 bytes_sent = 0;
    int                 cfg_writes = 0;
    int                 cycle_count = 0;

    versioned_tx_frame_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    initial begin : output_sink
        int gap;
        m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            gap = draw_gap();
            if (hold_request) begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic send_byte(logic [7:0] b, logic [19:0] len);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0000, len, b};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b, len);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame_data[k]) send_byte(frame_data[k], frame_len[k]);
    endtask

    task automatic place(int base, int cnt, logic [63:0] v);
        for (int i = 0; i < cnt; i++) hdr[base + i] = v[8 * i +: 8];
    endtask

    task automatic build_frame(t_frame_shape shape, t_fill fill);
        bit          v2, short_pick;
        int          off, n, plen_cap, k;
        logic [31:0] ver, plen, lo;
        logic [63:0] big;
        logic [19:0] len;
        frame_data.delete();
        frame_len.delete();
        if (shape == FR_NOISE) begin
            n = $urandom_range(1, 40);
            for (k = 0; k < n; k++) begin
                frame_data = {frame_data, 8'($urandom)};
                frame_len = {frame_len, 20'($urandom)};
            end
            // end the run at its last byte
            frame_len[n - 1] = 20'($urandom_range(0, n));
            return;
        end
        for (k = 0; k < 48; k++)
            hdr[k] = (fill == FILL_RANDOM) ? 8'($urandom) :
                     (fill == FILL_ZERO) ? 8'h00 : 8'hFF;
        v2 = (shape == FR_SHORT || shape == FR_LONG) ? 1'b1 :
             (shape == FR_V1) ? 1'b0 : 1'($urandom_range(0, 1));
        short_pick = (shape == FR_SHORT) ||
                     (shape == FR_LEN_SHIFT && v2 && $urandom_range(0, 1) == 1);
        if (!v2) begin
            ver = (fill == FILL_ONES) ? 32'd1 : (fill == FILL_ZERO) ? 32'd0 :
                  32'($urandom_range(0, 1));
        end else begin
            ver = (fill == FILL_ONES) ? 32'hFFFF_FFFF : (fill == FILL_ZERO) ? VER_V2 : $urandom;
            if (ver < VER_V2) ver = ver + VER_V2;
        end
        place(0, 4, ver);
        off = !v2 ? PAY_OFS_V1 : short_pick ? PAY_OFS_SHORT : PAY_OFS_LONG;
        plen_cap = (cur_max < 12) ? int'(cur_max) : 12;
        if (cur_max >= 40 && $urandom_range(0, 9) == 0) plen_cap = 40;
        plen = (fill == FILL_ONES) ? 32'(plen_cap) : (fill == FILL_ZERO) ? 32'd0 :
               32'($urandom_range(0, plen_cap));
        n = off + int'(plen);
        case (shape)
            FR_TOO_SHORT: begin
                if (!v2) n = $urandom_range(1, PAY_OFS_V1 - 1);
                else if ($urandom_range(0, 1) == 1) n = $urandom_range(1, PAY_OFS_SHORT - 1);
                else n = $urandom_range(PAY_OFS_SHORT, PAY_OFS_LONG - 1);
            end
            FR_TOO_LARGE: begin
                big = 64'(cur_max) + 64'd1 + 64'($urandom_range(0, 1000));
                plen = (fill == FILL_ONES || big > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : big[31:0];
                n = off + $urandom_range(0, 6);
            end
            FR_MISMATCH: begin
                if (plen > 0 && $urandom_range(0, 1) == 1)
                    n = n - $urandom_range(1, (plen < 5) ? int'(plen) : 5);
                else
                    n = n + $urandom_range(1, 5);
            end
            default: ;
        endcase
        len = 20'(n);
        if (!v2) begin
            place(OFS_V1_LEN, 4, plen);
        end else if (short_pick) begin
            place(OFS_LIMIT, 4, plen);
        end else begin
            place(OFS_V2_LEN, 4, plen);
            // keep the short layout from matching by accident
            lo = {hdr[31], hdr[30], hdr[29], hdr[28]};
            if (33'(lo) + 33'd32 == 33'(len)) hdr[28] = hdr[28] ^ 8'h01;
        end
        for (k = 0; k < n; k++) begin
            if (k < off) frame_data = {frame_data, hdr[k]};
            else if (fill == FILL_RANDOM) frame_data = {frame_data, 8'($urandom)};
            else frame_data = {frame_data, (fill == FILL_ZERO) ? 8'h00 : 8'hFF};
            frame_len = {frame_len, len};
        end
        if (shape == FR_LEN_SHIFT) begin
            for (k = 0; k < OFS_V1_LEN; k++)
                frame_len[k] = (fill == FILL_ONES) ? 20'hFFFFF : 20'($urandom);
            if ($urandom_range(0, 2) == 0) frame_len[off - 1] = len + 20'd1;
            if ($urandom_range(0, 1) == 1) frame_len[n - 1] = len - 20'($urandom_range(1, 3));
        end
    endtask

    function automatic t_frame_shape pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return FR_V1;
        if (r < 50) return FR_SHORT;
        if (r < 70) return FR_LONG;
        if (r < 78) return FR_TOO_SHORT;
        if (r < 85) return FR_TOO_LARGE;
        if (r < 92) return FR_MISMATCH;
        if (r < 96) return FR_LEN_SHIFT;
        return FR_NOISE;
    endfunction

    task automatic run_random(int target, int quiet_bytes);
        int count;
        count = 0;
        while (count < target) begin
            no_idle = (count < quiet_bytes);
            build_frame(pick_shape(), FILL_RANDOM);
            send_frame();
            count += frame_data.size();
        end
        no_idle = 1'b0;
    endtask

    // drop valid, drain all results, then let the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_max_payload(logic [31:0] v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.max_payload = v;
        cur_max = v;
        cfg_writes++;
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames at the reset limit
        build_frame(FR_V1, FILL_ZERO);          send_frame();
        build_frame(FR_V1, FILL_ONES);          send_frame();
        build_frame(FR_SHORT, FILL_ZERO);       send_frame();
        build_frame(FR_SHORT, FILL_ONES);       send_frame();
        build_frame(FR_LONG, FILL_ONES);        send_frame();
        build_frame(FR_LONG, FILL_RANDOM);      send_frame();
        send_byte(8'h00, 20'd0);
        build_frame(FR_TOO_SHORT, FILL_RANDOM); send_frame();
        build_frame(FR_TOO_SHORT, FILL_RANDOM); send_frame();
        build_frame(FR_TOO_LARGE, FILL_ONES);   send_frame();
        build_frame(FR_MISMATCH, FILL_RANDOM);  send_frame();
        build_frame(FR_LEN_SHIFT, FILL_ONES);   send_frame();
        build_frame(FR_NOISE, FILL_RANDOM);     send_frame();

        write_max_payload(32'd0);
        run_random(150, 0);
        write_max_payload(32'hFFFF_FFFF);
        run_random(150, 80);
        write_max_payload(32'($urandom_range(1, 20)));
        hold_request = 1'b1;
        run_random(200, 0);
        write_max_payload($urandom);
        run_random(100, 0);

        wait_idle();
        repeat (8) @(negedge i_clk);
        $display("Covered %0d bytes under %0d limit settings, with a long output hold",
                 bytes_sent, cfg_writes);
        $display("Checked %0d payload bytes; summaries ok %0d, short %0d, large %0d, mismatch %0d",
                 sb.payload_seen, sb.status_seen[ST_OK], sb.status_seen[ST_SHORT],
                 sb.status_seen[ST_TOO_LARGE], sb.status_seen[ST_MISMATCH]);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
